// ----- design/rfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants of the range fitted sigmoid
// fixed-point formats, log constants and the per-stage flag bundle
// ----------------------------------------------------------------------------
package rfs_pkg;

  // register indexes of the configuration port
  localparam logic REG_X_MIN = 1'b0;
  localparam logic REG_X_MAX = 1'b1;

  localparam int unsigned SAMPLE_BITS  = 32;
  localparam int unsigned FRAC_Q       = 28;
  localparam int unsigned DIV_BITS     = 32;   // ratio quotient, Q28 with 4 integer bits
  localparam int unsigned K_BITS       = 7;    // ln2 multiples of the exponent
  localparam int unsigned TAYLOR_TERMS = 14;

  localparam logic [30:0]       LN999_Q28 = 31'd1854017868;
  localparam logic [27:0]       LN2_Q28   = 28'd186065280;
  localparam logic [K_BITS-1:0] K_LIMIT   = 7'd40;

  typedef struct packed {
    logic err;      // empty range
    logic tail;     // far outside the fitted range
    logic rising;   // argument and range have the same sign
    logic mid;      // argument at the midpoint
  } flags_t;

  // floor(2^32 / n) for the series term divisions
  function automatic logic [32:0] taylor_recip(input int unsigned n);
    logic [32:0] r;
    case (n)
      1:       r = 33'd4294967296;
      2:       r = 33'd2147483648;
      3:       r = 33'd1431655765;
      4:       r = 33'd1073741824;
      5:       r = 33'd858993459;
      6:       r = 33'd715827882;
      7:       r = 33'd613566756;
      8:       r = 33'd536870912;
      9:       r = 33'd477218588;
      10:      r = 33'd429496729;
      11:      r = 33'd390451572;
      12:      r = 33'd357913941;
      13:      r = 33'd330382099;
      14:      r = 33'd306783378;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/rfs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_front: argument offset and ratio divider
// forms num and den, flags the special cases and divides |num|/|den| to Q28,
// one quotient bit per stage
// ----------------------------------------------------------------------------
module rfs_front import rfs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] x_min_i,
  input  logic signed [SAMPLE_BITS-1:0] x_max_i,
  output logic                       valid_o,
  output logic [DIV_BITS-1:0]        quo_o,
  output flags_t                     flags_o
);

  logic signed [34:0] num_w;
  logic signed [32:0] den_w;
  logic [34:0]        num_mag_w;
  logic [32:0]        den_mag_w;
  flags_t             flags_w;

  assign num_w = ($signed({{3{sample_i[31]}}, sample_i}) <<< 1)
               - $signed({{3{x_min_i[31]}}, x_min_i})
               - $signed({{3{x_max_i[31]}}, x_max_i});
  assign den_w = $signed({x_max_i[31], x_max_i}) - $signed({x_min_i[31], x_min_i});

  assign num_mag_w = num_w[34] ? 35'(-num_w) : 35'(num_w);
  assign den_mag_w = den_w[32] ? 33'(-den_w) : 33'(den_w);

  always_comb begin
    flags_w.err    = (den_w == '0);
    flags_w.tail   = num_mag_w > {den_mag_w[31:0], 3'b000};
    flags_w.rising = (!num_w[34] && num_w != '0) == (!den_w[32] && den_w != '0);
    flags_w.mid    = (num_mag_w == '0);
  end

  logic              v_q   [0:DIV_BITS];
  logic [31:0]       rem_q [0:DIV_BITS];
  logic [DIV_BITS-1:0] quo_q [0:DIV_BITS];
  logic [31:0]       ad_q  [0:DIV_BITS];
  logic [3:0]        lo_q  [0:DIV_BITS];
  flags_t            fl_q  [0:DIV_BITS];

  // entry stage: top bits of |num| seed the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {2'b00, num_mag_w[33:4]};
      lo_q[0]  <= num_mag_w[3:0];
      quo_q[0] <= '0;
      ad_q[0]  <= den_mag_w[31:0];
      fl_q[0]  <= flags_w;
    end
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    logic [32:0] trial_w;
    logic [32:0] diff_w;
    logic        ge_w;

    assign trial_w = {rem_q[i], lo_q[i][3]};
    assign ge_w    = trial_w >= {1'b0, ad_q[i]};
    assign diff_w  = trial_w - {1'b0, ad_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge_w ? diff_w[31:0] : trial_w[31:0];
        quo_q[i+1] <= {quo_q[i][DIV_BITS-2:0], ge_w};
        lo_q[i+1]  <= {lo_q[i][2:0], 1'b0};
        ad_q[i+1]  <= ad_q[i];
        fl_q[i+1]  <= fl_q[i];
      end
    end
  end

  assign valid_o = v_q[DIV_BITS];
  assign quo_o   = quo_q[DIV_BITS];
  assign flags_o = fl_q[DIV_BITS];

endmodule
`default_nettype wire

// ----- design/rfs_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_scale: exponent scaling
// multiplies the ratio by ln(999) and splits the result into k*ln2 + g,
// one bit of k per stage
// ----------------------------------------------------------------------------
module rfs_scale import rfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DIV_BITS-1:0] quo_i,
  input  flags_t              flags_i,
  output logic                valid_o,
  output logic [FRAC_Q-1:0]   g_o,
  output logic [K_BITS-1:0]   k_o,
  output flags_t              flags_o
);

  logic [63:0] prod_w;
  assign prod_w = 64'(quo_i) * 64'(LN999_Q28);

  logic              v_q   [0:K_BITS];
  logic [33:0]       rem_q [0:K_BITS];
  logic [K_BITS-1:0] k_q   [0:K_BITS];
  flags_t            fl_q  [0:K_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= prod_w[61:28];
      k_q[0]   <= '0;
      fl_q[0]  <= flags_i;
    end
  end

  for (genvar i = 0; i < K_BITS; i++) begin : g_red
    localparam logic [33:0] STEP = 34'(LN2_Q28) << (K_BITS - 1 - i);
    logic ge_w;

    assign ge_w = rem_q[i] >= STEP;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge_w ? rem_q[i] - STEP : rem_q[i];
        k_q[i+1]   <= {k_q[i][K_BITS-2:0], ge_w};
        fl_q[i+1]  <= fl_q[i];
      end
    end
  end

  assign valid_o = v_q[K_BITS];
  assign g_o     = rem_q[K_BITS][FRAC_Q-1:0];
  assign k_o     = k_q[K_BITS];
  assign flags_o = fl_q[K_BITS];

endmodule
`default_nettype wire

// ----- design/rfs_exp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_exp: exp(-g) in Q32 by an alternating Taylor series
// three stages per term: product, reciprocal multiply, correction and sum
// ----------------------------------------------------------------------------
module rfs_exp import rfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [FRAC_Q-1:0] g_i,
  input  logic [K_BITS-1:0] k_i,
  input  flags_t            flags_i,
  output logic              valid_o,
  output logic [32:0]       sum_o,
  output logic [K_BITS-1:0] k_o,
  output flags_t            flags_o
);

  localparam int unsigned NSTG = 3 * TAYLOR_TERMS;

  typedef struct packed {
    logic [31:0]       g32;
    logic [K_BITS-1:0] k;
    flags_t            fl;
    logic [32:0]       term;
    logic [33:0]       sum;
    logic [31:0]       p;
    logic [31:0]       q0;
  } exp_stage_t;

  logic       v_q  [0:NSTG];
  exp_stage_t st_q [0:NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].g32  <= {g_i, 4'b0000};
      st_q[0].k    <= k_i;
      st_q[0].fl   <= flags_i;
      st_q[0].term <= 33'h1_0000_0000;
      st_q[0].sum  <= 34'h1_0000_0000;
      st_q[0].p    <= '0;
      st_q[0].q0   <= '0;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
  end

  for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_term
    localparam int unsigned SA = 3 * (n - 1);
    localparam logic [32:0] RN = taylor_recip(n);
    localparam logic [31:0] NC = 32'(n);

    logic [64:0] prod_a_w;
    logic [64:0] prod_b_w;
    logic [31:0] rem_w;
    logic [31:0] q_w;
    exp_stage_t  a_w, b_w, c_w;

    assign prod_a_w = 65'(st_q[SA].term) * 65'(st_q[SA].g32);
    assign prod_b_w = 65'(st_q[SA+1].p) * 65'(RN);
    assign rem_w    = st_q[SA+2].p - 32'(st_q[SA+2].q0 * NC);
    assign q_w      = (rem_w >= NC) ? st_q[SA+2].q0 + 32'd1 : st_q[SA+2].q0;

    always_comb begin
      a_w    = st_q[SA];
      a_w.p  = prod_a_w[63:32];
      b_w    = st_q[SA+1];
      b_w.q0 = prod_b_w[63:32];
      c_w      = st_q[SA+2];
      c_w.term = {1'b0, q_w};
      c_w.sum  = (n % 2 == 1) ? st_q[SA+2].sum - 34'(q_w) : st_q[SA+2].sum + 34'(q_w);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[SA+1] <= a_w;
        st_q[SA+2] <= b_w;
        st_q[SA+3] <= c_w;
      end
    end
  end

  assign valid_o = v_q[NSTG];
  assign sum_o   = st_q[NSTG].sum[32:0];
  assign k_o     = st_q[NSTG].k;
  assign flags_o = st_q[NSTG].fl;

endmodule
`default_nettype wire

// ----- design/rfs_recip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_recip: logistic quotient and result selection
// e = exp(-g) >> k, s = round(e * 2^OUT_BITS / (2^32 + e)) by a restoring
// divider of one bit per stage, then special cases and saturation
// ----------------------------------------------------------------------------
module rfs_recip import rfs_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [32:0]         sum_i,
  input  logic [K_BITS-1:0]   k_i,
  input  flags_t              flags_i,
  output logic                valid_o,
  output logic [OUT_BITS-1:0] step_value_o,
  output logic                range_error_o
);

  localparam int unsigned NW = 34 + OUT_BITS;

  // exponent shift
  logic        e_v_q;
  logic [32:0] e_q;
  logic        n_v_q;
  flags_t      e_fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      n_v_q <= 1'b0;
    end else if (en_i) begin
      e_v_q <= valid_i;
      n_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= (k_i >= K_LIMIT) ? '0 : sum_i >> k_i;
      e_fl_q <= flags_i;
    end
  end

  // divisor and rounded dividend
  logic [33:0] d_w;
  logic [NW-1:0] n_w;
  assign d_w = 34'(e_q) + 34'h1_0000_0000;
  assign n_w = (NW'(e_q) << OUT_BITS) + NW'(d_w >> 1);

  logic                v_q   [0:OUT_BITS];
  logic [33:0]         rem_q [0:OUT_BITS];
  logic [OUT_BITS-1:0] lo_q  [0:OUT_BITS];
  logic [OUT_BITS-1:0] quo_q [0:OUT_BITS];
  logic [33:0]         d_q   [0:OUT_BITS];
  flags_t              fl_q  [0:OUT_BITS];

  assign v_q[0] = n_v_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_w[NW-1:OUT_BITS];
      lo_q[0]  <= n_w[OUT_BITS-1:0];
      quo_q[0] <= '0;
      d_q[0]   <= d_w;
      fl_q[0]  <= e_fl_q;
    end
  end

  for (genvar i = 0; i < OUT_BITS; i++) begin : g_div
    logic [34:0] trial_w;
    logic [34:0] diff_w;
    logic        ge_w;

    assign trial_w = {rem_q[i], lo_q[i][OUT_BITS-1]};
    assign ge_w    = trial_w >= {1'b0, d_q[i]};
    assign diff_w  = trial_w - {1'b0, d_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge_w ? diff_w[33:0] : trial_w[33:0];
        lo_q[i+1]  <= {lo_q[i][OUT_BITS-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][OUT_BITS-2:0], ge_w};
        d_q[i+1]   <= d_q[i];
        fl_q[i+1]  <= fl_q[i];
      end
    end
  end

  // result selection
  localparam logic [OUT_BITS-1:0] TOP  = '1;
  localparam logic [OUT_BITS-1:0] HALF = OUT_BITS'(1) << (OUT_BITS - 1);

  logic [OUT_BITS:0]   up_w;
  logic [OUT_BITS-1:0] res_w;
  flags_t              fl_w;

  assign fl_w = fl_q[OUT_BITS];
  assign up_w = {1'b1, {OUT_BITS{1'b0}}} - {1'b0, quo_q[OUT_BITS]};

  always_comb begin
    if (fl_w.err) begin
      res_w = '0;
    end else if (fl_w.tail) begin
      res_w = fl_w.rising ? TOP : '0;
    end else if (fl_w.mid) begin
      res_w = HALF;
    end else if (fl_w.rising) begin
      res_w = up_w[OUT_BITS] ? TOP : up_w[OUT_BITS-1:0];
    end else begin
      res_w = quo_q[OUT_BITS];
    end
  end

  logic                r_v_q;
  logic [OUT_BITS-1:0] r_val_q;
  logic                r_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (en_i) begin
      r_v_q <= v_q[OUT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_val_q <= res_w;
      r_err_q <= fl_w.err;
    end
  end

  assign valid_o       = r_v_q;
  assign step_value_o  = r_val_q;
  assign range_error_o = r_err_q;

endmodule
`default_nettype wire

// ----- design/range_fitted_sigmoid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// range_fitted_sigmoid: logistic step fitted to a configurable input range
// f(x) = 1/(1+exp(-t)), t = (2x - x_min - x_max) * ln(999) / (x_max - x_min)
// ----------------------------------------------------------------------------
// One signed Q16.16 sample enters per beat and one unsigned Q0.OUT_BITS result
// leaves per beat, so the block sustains one item every clock cycle while the
// skid register is empty. An accepted beat passes the chain of register stages:
// one entry stage and 32 single-bit stages of the ratio divider, one multiply
// and seven ln2 reduction stages, one entry and three stages for each of the
// fourteen series terms, two stages forming the final divisor, OUT_BITS
// single-bit stages of the logistic divider, a selection stage and the output
// register. A stalled output keeps its beat; the next result waits in a skid
// register, and only while that is occupied does the input see stall. The
// result reaches 0.001 at x_min and 0.999 at x_max and falls instead of rising
// when x_max < x_min. With x_max equal to x_min the result is 0 and
// range_error is set. Write x_min (index 0) and x_max (index 1) only while
// no beat is in flight.
// ----------------------------------------------------------------------------
module range_fitted_sigmoid import rfs_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  // sample beats
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OUT_BITS-1:0]    step_value_o,
  output logic                   range_error_o
);

  // range registers, reset to [-1.0, 1.0]
  logic signed [SAMPLE_BITS-1:0] x_min_q, x_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= -32'sd65536;
      x_max_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_MIN: x_min_q <= cfg_data_i;
        REG_X_MAX: x_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid register is holding a beat
  logic skid_valid_q;
  logic pipe_en;
  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  logic                in_acc;
  assign in_acc = in_valid_i && !skid_valid_q;

  // ratio divider
  logic                f_valid;
  logic [DIV_BITS-1:0] f_quo;
  flags_t              f_flags;

  rfs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (in_acc),
    .sample_i (sample_i),
    .x_min_i  (x_min_q),
    .x_max_i  (x_max_q),
    .valid_o  (f_valid),
    .quo_o    (f_quo),
    .flags_o  (f_flags)
  );

  // ln(999) scaling and ln2 split
  logic              s_valid;
  logic [FRAC_Q-1:0] s_g;
  logic [K_BITS-1:0] s_k;
  flags_t            s_flags;

  rfs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (f_valid),
    .quo_i   (f_quo),
    .flags_i (f_flags),
    .valid_o (s_valid),
    .g_o     (s_g),
    .k_o     (s_k),
    .flags_o (s_flags)
  );

  // series for exp(-g)
  logic              x_valid;
  logic [32:0]       x_sum;
  logic [K_BITS-1:0] x_k;
  flags_t            x_flags;

  rfs_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_valid),
    .g_i     (s_g),
    .k_i     (s_k),
    .flags_i (s_flags),
    .valid_o (x_valid),
    .sum_o   (x_sum),
    .k_o     (x_k),
    .flags_o (x_flags)
  );

  // logistic quotient and result
  logic                p_valid;
  logic [OUT_BITS-1:0] p_value;
  logic                p_err;

  rfs_recip #(
    .OUT_BITS (OUT_BITS)
  ) u_recip (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (pipe_en),
    .valid_i       (x_valid),
    .sum_i         (x_sum),
    .k_i           (x_k),
    .flags_i       (x_flags),
    .valid_o       (p_valid),
    .step_value_o  (p_value),
    .range_error_o (p_err)
  );

  // output register with skid stage
  logic                out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] out_value_q, out_value_d;
  logic                out_err_q, out_err_d;
  logic                skid_valid_d;
  logic [OUT_BITS-1:0] skid_value_q, skid_value_d;
  logic                skid_err_q, skid_err_d;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_err_d    = out_err_q;
    skid_valid_d = skid_valid_q;
    skid_value_d = skid_value_q;
    skid_err_d   = skid_err_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the parked beat first
        out_valid_d  = 1'b1;
        out_value_d  = skid_value_q;
        out_err_d    = skid_err_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = p_valid;
        out_value_d = p_value;
        out_err_d   = p_err;
      end
    end else if (pipe_en && p_valid) begin
      // output held, park the beat leaving the pipeline
      skid_valid_d = 1'b1;
      skid_value_d = p_value;
      skid_err_d   = p_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_err_q    <= out_err_d;
    skid_value_q <= skid_value_d;
    skid_err_q   <= skid_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign step_value_o  = out_value_q;
  assign range_error_o = out_err_q;

  // a parked beat always sits behind a beat on the output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while the output is empty");

  // a parked beat is kept while the output stays stalled
  a_skid_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("parked beat lost under stall");

  // an empty range always reads as zero
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_value_q == '0))
    else $error("range error with non-zero result");

endmodule
`default_nettype wire
